>>> design/aisu_pkg.sv
// aisu_pkg: shared widths, defaults and cell control type for the integer sorter
`timescale 1ns / 1ps
`default_nettype none
package aisu_pkg;

    localparam int VALUE_W       = 32;
    localparam int DEPTH_DEFAULT = 64;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> design/aisu_in_if.sv
// aisu_in_if: input channel carrying one element of the set per transaction
`timescale 1ns / 1ps
`default_nettype none
interface aisu_in_if;

    logic                               valid;
    logic                               ready;
    logic signed [aisu_pkg::VALUE_W-1:0] value;
    logic                               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface
`default_nettype wire

>>> design/aisu_out_if.sv
// aisu_out_if: output channel carrying one sorted element per transaction
`timescale 1ns / 1ps
`default_nettype none
interface aisu_out_if;

    logic                               valid;
    logic                               ready;
    logic signed [aisu_pkg::VALUE_W-1:0] value_res;
    logic                               last_res;

    modport source (output valid, output value_res, output last_res, input ready);
    modport sink   (input valid, input value_res, input last_res, output ready);

endinterface
`default_nettype wire

>>> design/aisu_cell.sv
// aisu_cell: one slot of the insertion chain, holding a value and its valid flag
`timescale 1ns / 1ps
`default_nettype none
module aisu_cell (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire aisu_pkg::cell_ctrl_t                ctrl,
    input  wire logic signed [aisu_pkg::VALUE_W-1:0] new_value,
    input  wire logic signed [aisu_pkg::VALUE_W-1:0] prev_value,
    input  wire logic                                prev_valid,
    input  wire logic                                prev_gt,
    input  wire logic signed [aisu_pkg::VALUE_W-1:0] next_value,
    input  wire logic                                next_valid,
    output      logic signed [aisu_pkg::VALUE_W-1:0] value,
    output      logic                                valid,
    output      logic                                gt
);
    import aisu_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   valid_reg;
    logic   valid_next;
    logic   take;

    // held value lies above the incoming one, so this slot moves up
    assign gt   = valid_reg && (value_reg > new_value);
    assign take = gt || (!valid_reg && prev_valid);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (ctrl.insert && take)
        begin
            value_next = prev_gt ? prev_value : new_value;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule
`default_nettype wire

>>> design/ascending_integer_sorter_unit.sv
// ascending_integer_sorter_unit: insertion chain sorter emitting each set in ascending order
//
// channel   role    payload
// in_ch     sink    value, last
// out_ch    source  value_res, last_res
//
// one element is taken per cycle while a set fills; each cell compares and inserts in place
// a set is emitted from cell 0, one element per out_ch transfer, as the chain shifts down
// input is held off while a set is being emitted; out_ch ready low simply pauses the shift
// a set closes on last or when DEPTH elements are held; the rest of that set is discarded
// rst_n clears all valid flags and the control state asynchronously
`timescale 1ns / 1ps
`default_nettype none
module ascending_integer_sorter_unit #(
    parameter int DEPTH = aisu_pkg::DEPTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    aisu_in_if.sink    in_ch,
    aisu_out_if.source out_ch
);
    import aisu_pkg::*;

    localparam logic [1:0] ST_FILL = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    value_t     cell_value [DEPTH];
    logic       cell_valid [DEPTH];
    logic       cell_gt    [DEPTH];
    cell_ctrl_t ctrl;

    logic in_fire;
    logic out_fire;
    logic will_fill;

    assign in_ch.ready = (state_reg != ST_EMIT);
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign out_ch.valid     = (state_reg == ST_EMIT);
    assign out_ch.value_res = cell_value[0];
    assign out_ch.last_res  = !cell_valid[1];
    assign out_fire         = out_ch.valid && out_ch.ready;

    // an insertion while the next-to-top slot is occupied fills the chain
    assign will_fill = cell_valid[DEPTH-2];

    assign ctrl.insert = in_fire && (state_reg == ST_FILL);
    assign ctrl.shift  = out_fire;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (in_fire && (in_ch.last || will_fill))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_fire && !cell_valid[1])
                begin
                    state_next = ST_FILL;
                end
            end
            ST_DROP:
            begin
                if (in_fire && in_ch.last)
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // remember a set cut short by a full chain until its last element
    logic drop_pending_reg;
    logic drop_pending_next;

    always_comb
    begin
        drop_pending_next = drop_pending_reg;
        if (ctrl.insert)
        begin
            drop_pending_next = will_fill && !in_ch.last;
        end
        else if (out_fire && !cell_valid[1])
        begin
            drop_pending_next = 1'b0;
        end
    end

    logic [1:0] state_after;
    always_comb
    begin
        state_after = state_next;
        if ((state_reg == ST_EMIT) && (state_next == ST_FILL) && drop_pending_reg)
        begin
            state_after = ST_DROP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_FILL;
            drop_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_after;
            drop_pending_reg <= drop_pending_next;
        end
    end

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        value_t prev_value;
        logic   prev_valid;
        logic   prev_gt;
        value_t next_value;
        logic   next_valid;

        if (k == 0)
        begin : g_head
            assign prev_value = '0;
            assign prev_valid = 1'b1;
            assign prev_gt    = 1'b0;
        end
        else
        begin : g_body
            assign prev_value = cell_value[k-1];
            assign prev_valid = cell_valid[k-1];
            assign prev_gt    = cell_gt[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_tail
            assign next_value = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_link
            assign next_value = cell_value[k+1];
            assign next_valid = cell_valid[k+1];
        end

        aisu_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_value  (in_ch.value),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .prev_gt    (prev_gt),
            .next_value (next_value),
            .next_valid (next_valid),
            .value      (cell_value[k]),
            .valid      (cell_valid[k]),
            .gt         (cell_gt[k])
        );
    end

endmodule
`default_nettype wire
